// ----- design/trpi_pkg.sv -----
// shared types and constants for the theta-rho path interpolator
// no dependencies
`timescale 1ns / 1ps

package trpi_pkg;

    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    localparam int unsigned HALF_PI_Q16 = 102944;
    localparam int unsigned TWO_PI_Q16  = 411775;
    localparam int unsigned ONE_Q16     = 65536;
    localparam int unsigned FEED_MIN    = 256;
    localparam int unsigned FEED_MAX    = 5120;

    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_KNEE = 2'd1;
    localparam logic [1:0] REG_FEED = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FIRST,
        OP_SETUP,
        OP_ABORT,
        OP_STEP,
        OP_DIV_STEP,
        OP_DIV_CNT,
        OP_DIV_RHO
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic run_active;
        logic small_dt;
        logic can_step;
    } t_sts;

endpackage

// ----- design/trpi_if.sv -----
// valid/ready channel interfaces for the interpolator
// depends on nothing
`timescale 1ns / 1ps

interface trpi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] point_theta;
    logic [19:0] point_rho;
    logic        first_point;
    modport source (output valid, cmd, point_theta, point_rho, first_point, input ready);
    modport sink (input valid, cmd, point_theta, point_rho, first_point, output ready);
endinterface

interface trpi_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] move_theta;
    logic [19:0] move_rho;
    logic [12:0] move_feed;
    logic        last_step;
    modport source (output valid, move_theta, move_rho, move_feed, last_step, input ready);
    modport sink (input valid, move_theta, move_rho, move_feed, last_step, output ready);
endinterface

interface trpi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/trpi_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned 40 by 32 bits
// depends on nothing
`timescale 1ns / 1ps

module trpi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [39:0] o_quo
);
    logic [39:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    assign n_shift = {r_rem[31:0], r_quo[39]};
    assign n_trial = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd40;
            r_quo  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (!n_trial[32]) begin
                r_rem <= n_trial;
                r_quo <= {r_quo[38:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[38:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

// ----- design/trpi_datapath.sv -----
// datapath: path state, step-angle adaption, divider, output register
// depends on trpi_pkg and trpi_div
`timescale 1ns / 1ps

module trpi_datapath #(
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trpi_pkg::t_ctl      i_ctl,
    output trpi_pkg::t_sts      o_sts,
    input  logic [31:0]         i_theta,
    input  logic [19:0]         i_rho,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic [18:0]         o_move_theta,
    output logic [19:0]         o_move_rho,
    output logic [12:0]         o_move_feed,
    output logic                o_last_step
);
    import trpi_pkg::*;

    localparam logic [STEP_COUNT_BITS-1:0] CAP = '1;

    logic [16:0] r_base;
    logic [15:0] r_knee;
    logic [12:0] r_feed;
    logic [31:0] r_anchor_theta, r_walk_theta, r_theta_step, r_new_theta;
    logic [19:0] r_anchor_rho, r_walk_rho, r_rho_step, r_new_rho;
    logic [STEP_COUNT_BITS-1:0] r_total, r_done;
    logic        r_run;
    logic [16:0] r_step;
    logic [32:0] r_adt;
    logic        r_dt_neg;
    logic [20:0] r_dr;
    logic        r_neg_rho;

    logic [39:0] d_num;
    logic [31:0] d_den;
    logic        d_busy;
    logic [39:0] d_quo;

    trpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_busy  (d_busy),
        .o_quo   (d_quo)
    );

    // segment setup terms
    logic [20:0] n_an, n_ap, n_a0;
    logic [16:0] n_a;
    logic [21:0] n_mx0;
    logic [16:0] n_mx, n_mn;
    logic        n_hi;
    logic        n_lo_neg;
    logic [32:0] n_dt;
    logic [20:0] n_drw;

    always_comb begin
        n_an = i_rho[19] ? 21'(-$signed({i_rho[19], i_rho})) : {1'b0, i_rho};
        n_ap = r_anchor_rho[19] ? 21'(-$signed({r_anchor_rho[19], r_anchor_rho}))
                                : {1'b0, r_anchor_rho};
        n_a0 = (n_an > n_ap) ? n_an : n_ap;
        n_a  = (n_a0 > 21'(ONE_Q16)) ? 17'(ONE_Q16) : n_a0[16:0];
        n_mx0 = {1'b0, r_base, 4'b0};
        n_mx  = (n_mx0 > 22'(HALF_PI_Q16)) ? 17'(HALF_PI_Q16) : n_mx0[16:0];
        n_mn  = {2'b0, r_base[16:2]};
        n_hi  = n_a > {1'b0, r_knee};
        // base above pi/2 makes the low-rho slope negative
        n_lo_neg = r_base > n_mx;
        n_dt  = 33'($signed({i_theta[31], i_theta})
                    - $signed({r_anchor_theta[31], r_anchor_theta}));
        n_drw = 21'($signed({i_rho[19], i_rho}) - $signed({r_anchor_rho[19], r_anchor_rho}));
    end

    // divider operand selection, registered multiplies feed it
    logic [39:0] r_prod;
    logic        r_knee_zero;
    logic [33:0] n_prod;
    logic [16:0] r_mx;
    logic        r_hi;
    logic        r_lo_neg;
    logic [16:0] r_base_s;
    logic [19:0] n_drmag;
    logic [36:0] n_rprod;

    always_comb begin
        n_prod = n_hi ? 34'(34'(n_a - {1'b0, r_knee}) * 34'(r_base - n_mn))
                      : 34'(34'(n_a) * 34'(n_lo_neg ? r_base - n_mx : n_mx - r_base));
        n_drmag = r_dr[20] ? 20'(-$signed(r_dr)) : r_dr[19:0];
        n_rprod = 37'(n_drmag) * 37'(r_step);
        d_num = '0;
        d_den = 32'd1;
        case (i_ctl.op)
            OP_DIV_STEP: begin
                d_num = r_prod;
                d_den = r_hi ? 32'(ONE_Q16 - 32'(r_knee)) : 32'(r_knee);
                if (d_den == 32'd0) d_den = 32'd1;
            end
            OP_DIV_CNT: begin
                d_num = 40'(r_adt);
                d_den = 32'(r_step);
            end
            OP_DIV_RHO: begin
                d_num = r_prod;
                d_den = r_adt[31:0];
            end
            default: ;
        endcase
    end

    // step result from the first quotient
    logic [17:0] n_stp;
    always_comb begin
        if (r_hi) n_stp = 18'({1'b0, r_base_s} - d_quo[17:0]);
        else if (r_knee_zero) n_stp = {1'b0, r_mx};
        else if (r_lo_neg) n_stp = 18'({1'b0, r_mx} + d_quo[17:0]);
        else n_stp = 18'({1'b0, r_mx} - d_quo[17:0]);
        if (n_stp == 18'd0 || n_stp[17]) n_stp = 18'd1;
    end

    logic [31:0] n_wt;
    logic [19:0] n_wr;
    logic [STEP_COUNT_BITS-1:0] n_done;
    logic [12:0] n_feed;
    logic [40:0] n_rq;

    always_comb begin
        n_wt   = r_walk_theta + r_theta_step;
        n_wr   = r_walk_rho + r_rho_step;
        n_done = r_done + 1'b1;
        n_feed = (r_feed < 13'(FEED_MIN)) ? 13'(FEED_MIN)
               : (r_feed > 13'(FEED_MAX)) ? 13'(FEED_MAX) : r_feed;
        n_rq   = r_neg_rho ? 41'(-$signed({1'b0, d_quo})) : {1'b0, d_quo};
    end

    // theta wrap: iterative subtract of 2pi*2^k, k from 14 down to 0
    logic [32:0] r_wrap;
    logic [4:0]  r_wcnt;
    logic        r_wbusy;
    logic [33:0] n_wsub;
    assign n_wsub = {1'b0, r_wrap} - (34'(TWO_PI_Q16) << (r_wcnt - 5'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 17'd1144;
            r_knee <= 16'd39322;
            r_feed <= 13'd1280;
            r_anchor_theta <= '0;
            r_anchor_rho <= '0;
            r_walk_theta <= '0;
            r_walk_rho <= '0;
            r_theta_step <= '0;
            r_rho_step <= '0;
            r_total <= '0;
            r_done <= '0;
            r_run <= 1'b0;
            r_wbusy <= 1'b0;
            r_wcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE: r_base <= i_cfg_data[16:0];
                    REG_KNEE: r_knee <= i_cfg_data[15:0];
                    REG_FEED: r_feed <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (r_wbusy) begin
                if (!n_wsub[33]) r_wrap <= n_wsub[32:0];
                r_wcnt <= r_wcnt - 5'd1;
                if (r_wcnt == 5'd1) r_wbusy <= 1'b0;
            end
            case (i_ctl.op)
                OP_FIRST: begin
                    r_anchor_theta <= i_theta;
                    r_anchor_rho <= i_rho;
                    r_run <= 1'b0;
                end
                OP_ABORT: begin
                    r_run <= 1'b0;
                    r_total <= '0;
                    r_done <= '0;
                end
                OP_SETUP: begin
                    r_prod <= 40'(n_prod);
                    r_hi <= n_hi;
                    r_lo_neg <= n_lo_neg;
                    r_knee_zero <= (r_knee == 16'd0);
                    r_mx <= n_mx;
                    r_base_s <= r_base;
                    r_adt <= n_dt[32] ? 33'(-$signed(n_dt)) : n_dt;
                    r_dt_neg <= n_dt[32];
                    r_dr <= n_drw;
                    r_new_theta <= i_theta;
                    r_new_rho <= i_rho;
                end
                OP_DIV_STEP: if (!d_busy && !i_ctl.div_start) begin
                    r_step <= n_stp[16:0];
                end
                OP_DIV_CNT: if (!d_busy && !i_ctl.div_start) begin
                    r_walk_theta <= r_anchor_theta;
                    r_walk_rho <= r_anchor_rho;
                    r_anchor_theta <= r_new_theta;
                    r_anchor_rho <= r_new_rho;
                    r_done <= '0;
                    if (r_adt < 33'(r_step)) begin
                        r_theta_step <= r_new_theta - r_anchor_theta;
                        r_rho_step <= r_dr[19:0];
                        r_total <= STEP_COUNT_BITS'(1);
                        r_run <= 1'b1;
                    end else begin
                        if (d_quo > 40'(CAP)) r_total <= CAP;
                        else r_total <= d_quo[STEP_COUNT_BITS-1:0];
                        r_theta_step <= r_dt_neg ? 32'(-$signed({15'd0, r_step}))
                                                 : {15'd0, r_step};
                        r_run <= (d_quo != 40'd0);
                        r_prod <= 40'(n_rprod);
                        r_neg_rho <= r_dr[20];
                    end
                end
                OP_DIV_RHO: if (!d_busy && !i_ctl.div_start) begin
                    r_rho_step <= n_rq[19:0];
                end
                OP_STEP: begin
                    if (!r_run || r_done >= r_total) begin
                        r_run <= 1'b0;
                    end else begin
                        r_done <= n_done;
                        r_walk_theta <= n_wt;
                        r_walk_rho <= n_wr;
                        o_move_rho <= n_wr;
                        o_move_feed <= n_feed;
                        o_last_step <= (n_done >= r_total);
                        if (n_done >= r_total) r_run <= 1'b0;
                        // negative angles biased up by a multiple of 2pi
                        r_wrap <= n_wt[31] ? {1'b1, n_wt} + 33'(TWO_PI_Q16 * 5216)
                                           : {1'b0, n_wt};
                        r_wbusy <= 1'b1;
                        r_wcnt <= 5'd15;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_move_theta = r_wrap[18:0];

    always_comb begin
        o_sts.div_busy   = d_busy || r_wbusy;
        o_sts.run_active = r_run;
        o_sts.small_dt   = (r_adt < 33'(r_step));
        o_sts.can_step   = r_run && (r_done < r_total);
    end
endmodule

// ----- design/trpi_ctrl.sv -----
// controller: command decode and sequencing of the shared divider
// depends on trpi_pkg
`timescale 1ns / 1ps

module trpi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_cmd,
    input  logic           i_first,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output trpi_pkg::t_ctl o_ctl,
    input  trpi_pkg::t_sts i_sts
);
    import trpi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DSTEP, S_DCNT, S_DRHO, S_WRAP, S_OUT
    } t_state;

    t_state r_state;
    logic   r_started;
    logic   in_xfer;

    always_comb begin
        o_ctl.op = OP_NONE;
        o_ctl.div_start = 1'b0;
        // hold input while a result waits in the output register
        o_in_ready = (r_state == S_IDLE) && !o_out_valid;
        in_xfer = i_in_valid && o_in_ready;
        case (r_state)
            S_IDLE: if (in_xfer) begin
                case (i_cmd)
                    CMD_POINT: if (!i_sts.run_active)
                        o_ctl.op = i_first ? OP_FIRST : OP_SETUP;
                    CMD_STEP:  o_ctl.op = OP_STEP;
                    CMD_ABORT: o_ctl.op = OP_ABORT;
                    default: ;
                endcase
            end
            S_DSTEP: begin o_ctl.op = OP_DIV_STEP; o_ctl.div_start = !r_started; end
            S_DCNT:  begin o_ctl.op = OP_DIV_CNT;  o_ctl.div_start = !r_started; end
            S_DRHO:  begin o_ctl.op = OP_DIV_RHO;  o_ctl.div_start = !r_started; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_started <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_xfer) begin
                    if (i_cmd == CMD_POINT && !i_sts.run_active && !i_first)
                        r_state <= S_DSTEP;
                    else if (i_cmd == CMD_STEP && i_sts.can_step)
                        r_state <= S_WRAP;
                    r_started <= 1'b0;
                end
                S_DSTEP, S_DCNT, S_DRHO: begin
                    if (!r_started) r_started <= 1'b1;
                    else if (!i_sts.div_busy) begin
                        r_started <= 1'b0;
                        if (r_state == S_DSTEP) r_state <= S_DCNT;
                        else if (r_state == S_DCNT && !i_sts.small_dt) r_state <= S_DRHO;
                        else r_state <= S_IDLE;
                    end
                end
                S_WRAP: if (!i_sts.div_busy && !o_out_valid) begin
                    o_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/theta_rho_path_interpolator.sv -----
// theta-rho path interpolator top level
// step command: result valid once the theta wrap completes in S_WRAP
// new point outside a run: three divider runs; two when one step covers the move
// first point, abort, idle step, other commands: stay idle; input waits while a result is held
// synchronous active-low reset restores register defaults and an idle, empty run
// depends on trpi_pkg, trpi_if, trpi_ctrl, trpi_datapath
`timescale 1ns / 1ps

module theta_rho_path_interpolator #(
    parameter int STEP_COUNT_BITS = 24
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    trpi_in_if.sink    in_ch,
    trpi_out_if.source out_ch,
    trpi_cfg_if.sink   cfg_ch
);
    import trpi_pkg::*;

    t_ctl ctl;
    t_sts sts;

    assign cfg_ch.ready = 1'b1;

    trpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .i_cmd       (in_ch.cmd),
        .i_first     (in_ch.first_point),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    trpi_datapath #(.STEP_COUNT_BITS(STEP_COUNT_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_theta      (in_ch.point_theta),
        .i_rho        (in_ch.point_rho),
        .i_cfg_we     (cfg_ch.valid),
        .i_cfg_idx    (cfg_ch.index),
        .i_cfg_data   (cfg_ch.data),
        .o_move_theta (out_ch.move_theta),
        .o_move_rho   (out_ch.move_rho),
        .o_move_feed  (out_ch.move_feed),
        .o_last_step  (out_ch.last_step)
    );
endmodule
